@@ hdl/hkm_pkg.sv @@
// Shared types, constants and the key character table for the key mapper.
package hkm_pkg;

  localparam int TIME_BITS  = 32;
  localparam int KIND_W     = 2;
  localparam int NOW_W      = 32;
  localparam int MOD_W      = 8;
  localparam int USAGE_W    = 8;
  localparam int CLS_W      = 4;
  localparam int CHAR_W     = 7;
  localparam int CNT_W      = 6;
  localparam int PERIOD_W   = 16;
  localparam int HOLD_W     = 20;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int ROM_IDX_W  = 6;
  localparam int CMP_W      = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

  localparam logic [USAGE_W-1:0] USAGE_RELEASE  = 8'h00;
  localparam logic [USAGE_W-1:0] USAGE_EMPTY    = 8'hFF;
  localparam logic [USAGE_W-1:0] USAGE_ENTER    = 8'h28;
  localparam logic [USAGE_W-1:0] USAGE_KP_ENTER = 8'h58;
  localparam logic [USAGE_W-1:0] USAGE_BKSP     = 8'h2A;
  localparam logic [USAGE_W-1:0] USAGE_TAB      = 8'h2B;
  localparam logic [USAGE_W-1:0] USAGE_RIGHT    = 8'h4F;
  localparam logic [USAGE_W-1:0] USAGE_LEFT     = 8'h50;
  localparam logic [USAGE_W-1:0] USAGE_DOWN     = 8'h51;
  localparam logic [USAGE_W-1:0] USAGE_UP       = 8'h52;
  localparam logic [USAGE_W-1:0] USAGE_ROM_LAST = 8'h38;
  localparam logic [MOD_W-1:0]   SHIFT_MASK     = 8'h22;

  localparam logic [PERIOD_W-1:0] SLOW_RST  = 16'd125;
  localparam logic [PERIOD_W-1:0] FAST_RST  = 16'd42;
  localparam logic [PERIOD_W-1:0] ACCEL_RST = 16'd2000;
  localparam logic [CNT_W-1:0]    BURST_RST = 6'd32;
  localparam logic [HOLD_W-1:0]   HOLD_RST  = 20'd30000;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_TAKE = 2'd3
  } kind_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_NONE        = 4'd0,
    CLS_ASCII       = 4'd1,
    CLS_ENTER       = 4'd2,
    CLS_BKSP        = 4'd3,
    CLS_TAB         = 4'd4,
    CLS_RIGHT       = 4'd5,
    CLS_LEFT        = 4'd6,
    CLS_SCROLL_DOWN = 4'd7,
    CLS_SCROLL_UP   = 4'd8
  } cls_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SLOW     = 3'd0,
    CFG_FAST     = 3'd1,
    CFG_ACCEL    = 3'd2,
    CFG_BURST    = 3'd3,
    CFG_MAX_HOLD = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_CHECK,
    ST_BURST,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_event;
    logic do_check;
    logic do_step;
    logic do_finish;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic tick_req;
    logic rep_on;
    logic hold_expired;
    logic pending_zero;
    logic step_ok;
  } dp_sts_t;

  // Character for a usage inside the table range; 0 where the key has none.
  function automatic logic [CHAR_W-1:0] hkm_char(input logic [ROM_IDX_W-1:0] idx,
                                                 input logic shift);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (idx >= 6'h04 && idx <= 6'h1D) begin
      c = shift ? (CHAR_W'(idx) + 7'h3D) : (CHAR_W'(idx) + 7'h5D);
    end else begin
      case (idx)
        6'h1E: c = shift ? 7'h21 : 7'h31;
        6'h1F: c = shift ? 7'h40 : 7'h32;
        6'h20: c = shift ? 7'h23 : 7'h33;
        6'h21: c = shift ? 7'h24 : 7'h34;
        6'h22: c = shift ? 7'h25 : 7'h35;
        6'h23: c = shift ? 7'h5E : 7'h36;
        6'h24: c = shift ? 7'h26 : 7'h37;
        6'h25: c = shift ? 7'h2A : 7'h38;
        6'h26: c = shift ? 7'h28 : 7'h39;
        6'h27: c = shift ? 7'h29 : 7'h30;
        6'h2C: c = 7'h20;
        6'h2D: c = shift ? 7'h5F : 7'h2D;
        6'h2E: c = shift ? 7'h2B : 7'h3D;
        6'h2F: c = shift ? 7'h7B : 7'h5B;
        6'h30: c = shift ? 7'h7D : 7'h5D;
        6'h31: c = shift ? 7'h7C : 7'h5C;
        6'h32: c = shift ? 7'h7C : 7'h5C;
        6'h33: c = shift ? 7'h3A : 7'h3B;
        6'h34: c = shift ? 7'h22 : 7'h27;
        6'h35: c = shift ? 7'h7E : 7'h60;
        6'h36: c = shift ? 7'h3C : 7'h2C;
        6'h37: c = shift ? 7'h3E : 7'h2E;
        6'h38: c = shift ? 7'h3F : 7'h2F;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

@@ hdl/hkm_in_if.sv @@
// Input channel: one poll per transfer.
interface hkm_in_if;
  logic                          valid;
  logic                          ready;
  logic [hkm_pkg::KIND_W-1:0]    kind;
  logic [hkm_pkg::NOW_W-1:0]     now_ms;
  logic [hkm_pkg::MOD_W-1:0]     modifier_bits;
  logic [hkm_pkg::USAGE_W-1:0]   key_usage;
  logic                          scroll_dir;

  modport source (output valid, kind, now_ms, modifier_bits, key_usage, scroll_dir,
                  input ready);
  modport sink   (input valid, kind, now_ms, modifier_bits, key_usage, scroll_dir,
                  output ready);
endinterface

@@ hdl/hkm_out_if.sv @@
// Result channel: one mapped key per transfer.
interface hkm_out_if;
  logic                          valid;
  logic                          ready;
  logic [hkm_pkg::CLS_W-1:0]     key_class;
  logic [hkm_pkg::CHAR_W-1:0]    ascii_char;
  logic [hkm_pkg::CNT_W-1:0]     scroll_count;

  modport source (output valid, key_class, ascii_char, scroll_count, input ready);
  modport sink   (input valid, key_class, ascii_char, scroll_count, output ready);
endinterface

@@ hdl/hid_key_map_with_scroll_repeat_unit.sv @@
// Key mapper with scroll typematic repeat: top level.
// Sequence: the input transfer is latched and the event decoded; for a tick poll a repeat
//   check, then while the repeat runs catch-up steps and a finish step, come before handoff.
// A new poll is taken only once the previous result has gone to the output register;
//   the catch-up loop adds one repeat period per cycle, up to max_burst repeats counted.
// A result waiting in the output register stalls the unit only once the next one is ready.
// Reset: rst_n synchronous, active low; repeat state cleared, config registers take defaults.
module hid_key_map_with_scroll_repeat_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  hkm_in_if.sink                         in_chan,
  hkm_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [hkm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hkm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hkm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hkm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hkm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_chan.kind),
    .in_now_ms        (in_chan.now_ms),
    .in_modifier_bits (in_chan.modifier_bits),
    .in_key_usage     (in_chan.key_usage),
    .in_scroll_dir    (in_chan.scroll_dir),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .out_key_class    (out_chan.key_class),
    .out_ascii_char   (out_chan.ascii_char),
    .out_scroll_count (out_chan.scroll_count)
  );

endmodule

@@ hdl/hkm_dp.sv @@
// Datapath: config registers, repeat state, key decode and catch-up arithmetic.
module hkm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hkm_pkg::dp_cmd_t               cmd,
  output hkm_pkg::dp_sts_t               sts,
  input  logic [hkm_pkg::KIND_W-1:0]     in_kind,
  input  logic [hkm_pkg::NOW_W-1:0]      in_now_ms,
  input  logic [hkm_pkg::MOD_W-1:0]      in_modifier_bits,
  input  logic [hkm_pkg::USAGE_W-1:0]    in_key_usage,
  input  logic                           in_scroll_dir,
  input  logic                           cfg_we,
  input  logic [hkm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hkm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [hkm_pkg::CLS_W-1:0]      out_key_class,
  output logic [hkm_pkg::CHAR_W-1:0]     out_ascii_char,
  output logic [hkm_pkg::CNT_W-1:0]      out_scroll_count
);
  import hkm_pkg::*;

  // latched poll
  kind_t                 kind_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [MOD_W-1:0]      mod_r;
  logic [USAGE_W-1:0]    usage_r;
  logic                  dir_r;

  // configuration
  logic [PERIOD_W-1:0]   slow_r, fast_r, accel_r;
  logic [CNT_W-1:0]      burst_r;
  logic [HOLD_W-1:0]     max_hold_r;

  // repeat state
  logic                  rep_on_r, rep_on_nxt;
  logic                  rep_up_r, rep_up_nxt;
  logic [TIME_BITS-1:0]  hold_start_r, hold_start_nxt;
  logic [TIME_BITS-1:0]  next_due_r, next_due_nxt;
  logic [CNT_W-1:0]      pending_r, pending_nxt;
  logic [PERIOD_W-1:0]   period_r, period_nxt;

  // result being built, and the output register
  cls_t                  res_cls_r, res_cls_nxt;
  logic [CHAR_W-1:0]     res_ch_r, res_ch_nxt;
  logic [CNT_W-1:0]      res_cnt_r, res_cnt_nxt;
  cls_t                  out_cls_r;
  logic [CHAR_W-1:0]     out_ch_r;
  logic [CNT_W-1:0]      out_cnt_r;

  cls_t                  cls_evt;
  logic [CHAR_W-1:0]     ch_evt;
  logic                  key_evt;
  logic [TIME_BITS-1:0]  elapsed;
  logic [TIME_BITS-1:0]  lag;
  logic                  hold_expired;
  logic                  accel_reached;
  logic                  behind;
  logic                  step_ok;
  logic                  far_behind;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= kind_t'(in_kind);
      now_r   <= in_now_ms[TIME_BITS-1:0];
      mod_r   <= in_modifier_bits;
      usage_r <= in_key_usage;
      dir_r   <= in_scroll_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r     <= SLOW_RST;
      fast_r     <= FAST_RST;
      accel_r    <= ACCEL_RST;
      burst_r    <= BURST_RST;
      max_hold_r <= HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SLOW:     slow_r     <= cfg_wdata[PERIOD_W-1:0];
        CFG_FAST:     fast_r     <= cfg_wdata[PERIOD_W-1:0];
        CFG_ACCEL:    accel_r    <= cfg_wdata[PERIOD_W-1:0];
        CFG_BURST:    burst_r    <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_HOLD: max_hold_r <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // key decode
  always_comb begin
    cls_evt = CLS_NONE;
    ch_evt  = '0;
    key_evt = (kind_r == KIND_KEY) && (usage_r != USAGE_EMPTY);
    unique case (usage_r)
      USAGE_ENTER, USAGE_KP_ENTER: cls_evt = CLS_ENTER;
      USAGE_BKSP:  cls_evt = CLS_BKSP;
      USAGE_TAB:   cls_evt = CLS_TAB;
      USAGE_RIGHT: cls_evt = CLS_RIGHT;
      USAGE_LEFT:  cls_evt = CLS_LEFT;
      USAGE_DOWN:  cls_evt = CLS_SCROLL_DOWN;
      USAGE_UP:    cls_evt = CLS_SCROLL_UP;
      default: begin
        if (usage_r <= USAGE_ROM_LAST) begin
          ch_evt = hkm_char(usage_r[ROM_IDX_W-1:0], |(mod_r & SHIFT_MASK));
          if (ch_evt != '0) cls_evt = CLS_ASCII;
        end
      end
    endcase
    if (!key_evt) begin
      cls_evt = CLS_NONE;
      ch_evt  = '0;
    end
  end

  // time compares; due-time tests are signed on the wrapped difference
  assign elapsed       = now_r - hold_start_r;
  assign lag           = now_r - next_due_r;
  assign hold_expired  = CMP_W'(elapsed) >= CMP_W'(max_hold_r);
  assign accel_reached = CMP_W'(elapsed) >= CMP_W'(accel_r);
  assign behind        = !lag[TIME_BITS-1];
  assign step_ok       = behind && (pending_r < burst_r);
  assign far_behind    = behind && (lag > TIME_BITS'(period_r));

  always_comb begin
    sts.tick_req     = ((kind_r == KIND_NONE) || (kind_r == KIND_KEY)) && (cls_evt == CLS_NONE);
    sts.rep_on       = rep_on_r;
    sts.hold_expired = hold_expired;
    sts.pending_zero = (pending_r == '0);
    sts.step_ok      = step_ok;
  end

  always_comb begin
    rep_on_nxt     = rep_on_r;
    rep_up_nxt     = rep_up_r;
    hold_start_nxt = hold_start_r;
    next_due_nxt   = next_due_r;
    pending_nxt    = pending_r;
    period_nxt     = period_r;
    res_cls_nxt    = res_cls_r;
    res_ch_nxt     = res_ch_r;
    res_cnt_nxt    = res_cnt_r;

    if (cmd.do_event) begin
      res_cls_nxt = cls_evt;
      res_ch_nxt  = ch_evt;
      res_cnt_nxt = '0;
      unique case (kind_r)
        KIND_TAKE: begin
          if (rep_on_r && (rep_up_r == dir_r) && (pending_r != '0)) begin
            res_cnt_nxt = pending_r;
            pending_nxt = '0;
          end
        end
        KIND_ERR: begin
          rep_on_nxt  = 1'b0;
          pending_nxt = '0;
        end
        default: begin
          if (key_evt) begin
            if ((usage_r == USAGE_DOWN) || (usage_r == USAGE_UP)) begin
              rep_on_nxt     = 1'b1;
              rep_up_nxt     = (usage_r == USAGE_UP);
              hold_start_nxt = now_r;
              next_due_nxt   = now_r + TIME_BITS'(slow_r);
            end else begin
              rep_on_nxt = 1'b0;
            end
            pending_nxt = '0;
          end
        end
      endcase
    end

    if (cmd.do_check) begin
      period_nxt = accel_reached ? fast_r : slow_r;
      if (rep_on_r && hold_expired) begin
        rep_on_nxt  = 1'b0;
        pending_nxt = '0;
      end
    end

    // one period per cycle; on exit restart the clock if far behind
    if (cmd.do_step) begin
      if (step_ok) begin
        pending_nxt  = pending_r + CNT_W'(1);
        next_due_nxt = next_due_r + TIME_BITS'(period_r);
      end else if (far_behind) begin
        next_due_nxt = now_r + TIME_BITS'(period_r);
      end
    end

    if (cmd.do_finish && (pending_r != '0)) begin
      pending_nxt = pending_r - CNT_W'(1);
      res_cls_nxt = rep_up_r ? CLS_SCROLL_UP : CLS_SCROLL_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_on_r     <= 1'b0;
      rep_up_r     <= 1'b0;
      hold_start_r <= '0;
      next_due_r   <= '0;
      pending_r    <= '0;
    end else begin
      rep_on_r     <= rep_on_nxt;
      rep_up_r     <= rep_up_nxt;
      hold_start_r <= hold_start_nxt;
      next_due_r   <= next_due_nxt;
      pending_r    <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r  <= period_nxt;
    res_cls_r <= res_cls_nxt;
    res_ch_r  <= res_ch_nxt;
    res_cnt_r <= res_cnt_nxt;
    if (cmd.load_out) begin
      out_cls_r <= res_cls_r;
      out_ch_r  <= res_ch_r;
      out_cnt_r <= res_cnt_r;
    end
  end

  assign out_key_class    = out_cls_r;
  assign out_ascii_char   = out_ch_r;
  assign out_scroll_count = out_cnt_r;

  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_event && (kind_r == KIND_ERR) |=> !rep_on_r && (pending_r == '0))
    else $error("bus error left the repeat running");

  a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_step && step_ok |=> pending_r == $past(pending_r) + CNT_W'(1))
    else $error("catch-up step did not count a repeat");

  a_emit_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_finish && (pending_r != '0) |=>
      (res_cls_r == CLS_SCROLL_UP) || (res_cls_r == CLS_SCROLL_DOWN))
    else $error("pending repeat not emitted as scroll");

endmodule

@@ hdl/hkm_ctrl.sv @@
// Controller: sequences decode, repeat check, catch-up loop and result handoff.
module hkm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hkm_pkg::dp_sts_t  sts,
  output hkm_pkg::dp_cmd_t  cmd
);
  import hkm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EVENT;
        end
      end
      ST_EVENT: begin
        cmd.do_event = 1'b1;
        state_nxt    = sts.tick_req ? ST_CHECK : ST_DONE;
      end
      ST_CHECK: begin
        cmd.do_check = 1'b1;
        if (!sts.rep_on || sts.hold_expired) state_nxt = ST_DONE;
        else if (sts.pending_zero)          state_nxt = ST_BURST;
        else                                state_nxt = ST_FINISH;
      end
      ST_BURST: begin
        cmd.do_step = 1'b1;
        if (!sts.step_ok) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.do_finish = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  a_burst_needs_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BURST) |-> sts.rep_on)
    else $error("catch-up loop running with no repeat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> !$past(cmd.load_out) || out_valid_r)
    else $error("result register lost a pending transfer");

  a_accept_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !cmd.load_out && !in_ready)
    else $error("poll accepted while another is in flight");

endmodule
